// File: hdl/dpts_pkg.sv
// Shared types and constants for the dual PLL tuning word sequencer.
package dpts_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_FREQ = 2'd0;
    localparam logic [1:0] REG_MAX_FREQ = 2'd1;

    localparam logic [23:0] MIN_FREQ_RST = 24'd50000;
    localparam logic [23:0] MAX_FREQ_RST = 24'd3000000;

    // Result word kinds.
    localparam logic [2:0] KIND_BAND = 3'd0;
    localparam logic [2:0] KIND_SYN1 = 3'd1;
    localparam logic [2:0] KIND_SYN2 = 3'd2;
    localparam logic [2:0] KIND_TENS = 3'd3;
    localparam logic [2:0] KIND_HUND = 3'd4;

    localparam logic [7:0] BAND_AUTO = 8'hFF;

    // Automatic band ladder thresholds, 10 Hz units.
    localparam logic [23:0] THR_B9 = 24'd9999999;
    localparam logic [23:0] THR_B8 = 24'd2500000;
    localparam logic [23:0] THR_B7 = 24'd2150000;
    localparam logic [23:0] THR_B6 = 24'd1850000;
    localparam logic [23:0] THR_B5 = 24'd1450000;
    localparam logic [23:0] THR_B4 = 24'd1050000;
    localparam logic [23:0] THR_B3 = 24'd750000;
    localparam logic [23:0] THR_B2 = 24'd400000;
    localparam logic [23:0] THR_B1 = 24'd250000;

    // Reciprocals for division by constants; exact for the operand widths used.
    localparam logic [23:0] RCP_DIV10   = 24'd13421773;  // shift 27, 24-bit operand
    localparam logic [24:0] RCP_DIV100  = 25'd21474837;  // shift 31
    localparam logic [24:0] RCP_DIV10K  = 25'd27487791;  // shift 38
    localparam logic [24:0] RCP_DIV50K  = 25'd21990233;  // shift 40
    localparam logic [18:0] RCP_DIV1K_S = 19'd268436;    // shift 28, 18-bit operand

    localparam logic [9:0]  KHZ_FOLD   = 10'd500;
    localparam logic [10:0] KHZ_OFFSET = 11'd560;
    localparam logic [15:0] SYN2_LO_ADD = 16'd12;
    localparam logic [15:0] SYN2_HI_SUB = 16'd18;
    localparam logic [7:0]  BAND_SYN2_SPLIT = 8'd6;

    // Word slots of one request, in emission order.
    localparam int unsigned NUM_SLOTS = 11;
    localparam logic [3:0] SLOT_BAND  = 4'd0;
    localparam logic [3:0] SLOT_S1_A  = 4'd1;
    localparam logic [3:0] SLOT_S1_B  = 4'd2;
    localparam logic [3:0] SLOT_S1_C  = 4'd3;
    localparam logic [3:0] SLOT_S1_D  = 4'd4;
    localparam logic [3:0] SLOT_S2_A  = 4'd5;
    localparam logic [3:0] SLOT_S2_B  = 4'd6;
    localparam logic [3:0] SLOT_S2_C  = 4'd7;
    localparam logic [3:0] SLOT_S2_D  = 4'd8;
    localparam logic [3:0] SLOT_TENS  = 4'd9;
    localparam logic [3:0] SLOT_HUND  = 4'd10;

    typedef struct packed {
        logic        valid;
        logic [23:0] freq;
        logic        force_rs;
        logic [7:0]  ovr;
        logic [3:0]  auto_band;
        logic        keep_band;
    } t_front;

    typedef struct packed {
        t_front      req;
        logic [3:0]  tens;
        logic [3:0]  hund;
        logic [10:0] khz;
        logic [10:0] count;
        logic [8:0]  cnt5;
    } t_digit;

    typedef struct packed {
        logic [23:0] freq;
        logic [7:0]  band;
        logic [10:0] khz;
        logic [11:0] syn2_x;
        logic [3:0]  tens;
        logic [3:0]  hund;
    } t_set;

endpackage

// File: hdl/dpts_front.sv
// Configuration registers, request register, frequency wrap and band ladder stage.
module dpts_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [23:0]          i_cfg_data,
    input  logic                 i_adv,
    input  logic                 i_in_valid,
    input  logic [23:0]          i_frequency,
    input  logic                 i_force_resend,
    input  logic [7:0]           i_band_override,
    output dpts_pkg::t_front     o_front
);

    logic [23:0]      r_min_freq;
    logic [23:0]      r_max_freq;
    dpts_pkg::t_front r_req;
    dpts_pkg::t_front r_wrap;
    dpts_pkg::t_front n_wrap;
    logic [23:0]      step1;
    logic [23:0]      wrapped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq <= dpts_pkg::MIN_FREQ_RST;
            r_max_freq <= dpts_pkg::MAX_FREQ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpts_pkg::REG_MIN_FREQ: r_min_freq <= i_cfg_data;
                dpts_pkg::REG_MAX_FREQ: r_max_freq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The two wrap steps apply in sequence, so odd limits behave as written.
    always_comb begin
        step1   = (r_req.freq > r_max_freq) ? r_min_freq : r_req.freq;
        wrapped = (step1 < r_min_freq) ? r_max_freq : step1;

        n_wrap           = r_req;
        n_wrap.freq      = wrapped;
        n_wrap.keep_band = (wrapped >= dpts_pkg::THR_B9);
        if (wrapped < dpts_pkg::THR_B1)      n_wrap.auto_band = 4'd1;
        else if (wrapped < dpts_pkg::THR_B2) n_wrap.auto_band = 4'd2;
        else if (wrapped < dpts_pkg::THR_B3) n_wrap.auto_band = 4'd3;
        else if (wrapped < dpts_pkg::THR_B4) n_wrap.auto_band = 4'd4;
        else if (wrapped < dpts_pkg::THR_B5) n_wrap.auto_band = 4'd5;
        else if (wrapped < dpts_pkg::THR_B6) n_wrap.auto_band = 4'd6;
        else if (wrapped < dpts_pkg::THR_B7) n_wrap.auto_band = 4'd7;
        else if (wrapped < dpts_pkg::THR_B8) n_wrap.auto_band = 4'd8;
        else                                 n_wrap.auto_band = 4'd9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid  <= 1'b0;
            r_wrap.valid <= 1'b0;
        end else if (i_adv) begin
            r_req.valid     <= i_in_valid;
            r_req.freq      <= i_frequency;
            r_req.force_rs  <= i_force_resend;
            r_req.ovr       <= i_band_override;
            r_req.auto_band <= 4'd0;
            r_req.keep_band <= 1'b0;
            r_wrap          <= n_wrap;
        end
    end

    assign o_front = r_wrap;

endmodule

// File: hdl/dpts_digits.sv
// Decimal split stages: quotients by reciprocal multiply, then digits and kHz code.
module dpts_digits (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  dpts_pkg::t_front i_front,
    output dpts_pkg::t_digit o_digit
);

    typedef struct packed {
        dpts_pkg::t_front req;
        logic [20:0]      q10;
        logic [17:0]      q100;
        logic [10:0]      count;
        logic [8:0]       cnt5;
    } t_quot;

    typedef struct packed {
        dpts_pkg::t_front req;
        logic [3:0]       tens;
        logic [3:0]       hund;
        logic [17:0]      q100;
        logic [8:0]       q1000;
        logic [10:0]      count;
        logic [8:0]       cnt5;
    } t_split;

    t_quot            r_quot;
    t_quot            n_quot;
    t_split           r_split;
    t_split           n_split;
    dpts_pkg::t_digit r_digit;
    dpts_pkg::t_digit n_digit;

    logic [47:0] p10;
    logic [48:0] p100;
    logic [48:0] p10k;
    logic [48:0] p50k;
    logic [36:0] p1000;
    logic [7:0]  tens_w;
    logic [7:0]  hund_w;
    logic [9:0]  khz_raw;
    logic [9:0]  khz_fold;

    // Four independent constant multiplies on the wrapped frequency.
    always_comb begin
        p10  = 48'(i_front.freq) * 48'(dpts_pkg::RCP_DIV10);
        p100 = 49'(i_front.freq) * 49'(dpts_pkg::RCP_DIV100);
        p10k = 49'(i_front.freq) * 49'(dpts_pkg::RCP_DIV10K);
        p50k = 49'(i_front.freq) * 49'(dpts_pkg::RCP_DIV50K);
        n_quot.req   = i_front;
        n_quot.q10   = p10[27 +: 21];
        n_quot.q100  = p100[31 +: 18];
        n_quot.count = p10k[38 +: 11];
        n_quot.cnt5  = p50k[40 +: 9];
    end

    // Remainders are taken modulo 256; ten times x is 8x plus 2x.
    // The hundreds quotient is divided by one thousand for the kHz remainder.
    always_comb begin
        p1000  = 37'(r_quot.q100) * 37'(dpts_pkg::RCP_DIV1K_S);
        tens_w = r_quot.req.freq[7:0] - {r_quot.q10[4:0], 3'b000}
                 - {r_quot.q10[6:0], 1'b0};
        hund_w = r_quot.q10[7:0] - {r_quot.q100[4:0], 3'b000}
                 - {r_quot.q100[6:0], 1'b0};
        n_split.req   = r_quot.req;
        n_split.tens  = tens_w[3:0];
        n_split.hund  = hund_w[3:0];
        n_split.q100  = r_quot.q100;
        n_split.q1000 = p1000[28 +: 9];
        n_split.count = r_quot.count;
        n_split.cnt5  = r_quot.cnt5;
    end

    // One thousand times x is 1024x minus 24x, so modulo 1024 only 24x remains.
    always_comb begin
        khz_raw  = r_split.q100[9:0] + {r_split.q1000[5:0], 4'b0000}
                   + {r_split.q1000[6:0], 3'b000};
        khz_fold = (khz_raw >= dpts_pkg::KHZ_FOLD) ? (khz_raw - dpts_pkg::KHZ_FOLD) : khz_raw;
        n_digit.req   = r_split.req;
        n_digit.tens  = r_split.tens;
        n_digit.hund  = r_split.hund;
        n_digit.khz   = {1'b0, khz_fold} + dpts_pkg::KHZ_OFFSET;
        n_digit.count = r_split.count;
        n_digit.cnt5  = r_split.cnt5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot.req.valid  <= 1'b0;
            r_split.req.valid <= 1'b0;
            r_digit.req.valid <= 1'b0;
        end else if (i_adv) begin
            r_quot  <= n_quot;
            r_split <= n_split;
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

// File: hdl/dpts_decide.sv
// Remembered latch state and the choice of which words a request sends.
module dpts_decide (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  dpts_pkg::t_digit i_digit,
    output dpts_pkg::t_set   o_set,
    output logic [10:0]      o_mask
);

    logic [7:0]  r_cur_band;
    logic [7:0]  r_prev_band;
    logic [10:0] r_prev_khz;
    logic [9:0]  r_prev_cnt;
    logic [3:0]  r_prev_tens;

    logic [7:0]  band;
    logic [7:0]  prev_band_eff;
    logic [10:0] prev_khz_eff;
    logic [9:0]  prev_cnt_eff;
    logic [3:0]  prev_tens_eff;
    logic        band_chg;
    logic        khz_chg;
    logic        cnt_chg;
    logic        tens_chg;
    logic [15:0] syn2_x;
    logic        commit;

    always_comb begin
        if (i_digit.req.ovr != dpts_pkg::BAND_AUTO) begin
            band = i_digit.req.ovr;
        end else if (i_digit.req.keep_band) begin
            band = r_cur_band;
        end else begin
            band = {4'd0, i_digit.req.auto_band};
        end

        prev_band_eff = i_digit.req.force_rs ? 8'd0 : r_prev_band;
        prev_khz_eff  = i_digit.req.force_rs ? 11'd0 : r_prev_khz;
        prev_cnt_eff  = i_digit.req.force_rs ? 10'd0 : r_prev_cnt;
        band_chg      = (band != prev_band_eff);
        // Sending a band forgets the tens digit, so a nonzero tens digit is sent again.
        prev_tens_eff = (i_digit.req.force_rs || band_chg) ? 4'd0 : r_prev_tens;

        khz_chg  = (i_digit.khz != prev_khz_eff);
        cnt_chg  = (i_digit.count[9:0] != prev_cnt_eff);
        tens_chg = (i_digit.tens != prev_tens_eff);

        if (band < dpts_pkg::BAND_SYN2_SPLIT) begin
            syn2_x = 16'(i_digit.cnt5) + dpts_pkg::SYN2_LO_ADD;
        end else begin
            syn2_x = 16'(i_digit.cnt5) - dpts_pkg::SYN2_HI_SUB;
        end

        o_set.freq   = i_digit.req.freq;
        o_set.band   = band;
        o_set.khz    = i_digit.khz;
        o_set.syn2_x = syn2_x[11:0];
        o_set.tens   = i_digit.tens;
        o_set.hund   = i_digit.hund;

        o_mask = {1'b1, tens_chg, {4{cnt_chg}}, {4{khz_chg}}, band_chg};
        commit = i_adv && i_digit.req.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_band  <= 8'd0;
            r_prev_band <= 8'd0;
            r_prev_khz  <= 11'd0;
            r_prev_cnt  <= 10'd0;
            r_prev_tens <= 4'd0;
        end else if (commit) begin
            r_cur_band  <= band;
            r_prev_band <= band;
            r_prev_khz  <= i_digit.khz;
            r_prev_cnt  <= i_digit.count[9:0];
            r_prev_tens <= tens_chg ? i_digit.tens : prev_tens_eff;
        end
    end

endmodule

// File: hdl/dpts_emit.sv
// Word set register and output register: sends the pending words one per cycle unless stalled.
module dpts_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  dpts_pkg::t_set i_set,
    input  logic [10:0]    i_mask,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [2:0]     o_kind,
    output logic [7:0]     o_value,
    output logic [23:0]    o_frequency_out,
    output logic           o_last
);

    dpts_pkg::t_set r_set;
    logic [10:0]    r_mask;
    logic [10:0]    n_mask;
    logic           r_out_valid;
    logic [2:0]     r_kind;
    logic [7:0]     r_value;
    logic [23:0]    r_freq;
    logic           r_last;

    logic           out_free;
    logic [3:0]     slot;
    logic [2:0]     kind;
    logic [7:0]     value;

    assign out_free = !r_out_valid || !i_out_stall;
    // The hundreds word is always present and always sent last.
    assign o_take   = !r_mask[dpts_pkg::SLOT_HUND] || (out_free && (r_mask[9:0] == 10'd0));

    always_comb begin
        slot = dpts_pkg::SLOT_HUND;
        for (int i = dpts_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) slot = 4'(i);
        end

        case (slot)
            dpts_pkg::SLOT_BAND: begin
                kind  = dpts_pkg::KIND_BAND;
                value = r_set.band;
            end
            dpts_pkg::SLOT_S1_A: begin
                kind  = dpts_pkg::KIND_SYN1;
                value = 8'h30;
            end
            dpts_pkg::SLOT_S1_B: begin
                kind  = dpts_pkg::KIND_SYN1;
                value = 8'h20 + {5'd0, r_set.khz[10:8]};
            end
            dpts_pkg::SLOT_S1_C: begin
                kind  = dpts_pkg::KIND_SYN1;
                value = 8'h10 + {4'd0, r_set.khz[7:4]};
            end
            dpts_pkg::SLOT_S1_D: begin
                kind  = dpts_pkg::KIND_SYN1;
                value = {4'd0, r_set.khz[3:0]};
            end
            dpts_pkg::SLOT_S2_A: begin
                kind  = dpts_pkg::KIND_SYN2;
                value = 8'h30;
            end
            dpts_pkg::SLOT_S2_B: begin
                kind  = dpts_pkg::KIND_SYN2;
                value = 8'h20;
            end
            dpts_pkg::SLOT_S2_C: begin
                kind  = dpts_pkg::KIND_SYN2;
                value = 8'h10 + r_set.syn2_x[11:4];
            end
            dpts_pkg::SLOT_S2_D: begin
                kind  = dpts_pkg::KIND_SYN2;
                value = {4'd0, r_set.syn2_x[3:0]};
            end
            dpts_pkg::SLOT_TENS: begin
                kind  = dpts_pkg::KIND_TENS;
                value = {4'd0, r_set.tens} + 8'd1;
            end
            default: begin
                kind  = dpts_pkg::KIND_HUND;
                value = {4'd0, r_set.hund} + 8'd1;
            end
        endcase

        n_mask = r_mask;
        if (out_free) n_mask[slot] = 1'b0;
        if (i_load) n_mask = i_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= 11'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (out_free) begin
                r_out_valid <= (r_mask != 11'd0);
                r_kind      <= kind;
                r_value     <= value;
                r_freq      <= r_set.freq;
                r_last      <= (slot == dpts_pkg::SLOT_HUND);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_set <= i_set;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_value         = r_value;
    assign o_frequency_out = r_freq;
    assign o_last          = r_last;

endmodule

// File: hdl/dual_pll_tuning_word_sequencer.sv
// Top level of the dual PLL tuning word sequencer.
//
//  Channel   Direction  Handshake                 Word contents
//  request   in         i_in_valid / o_in_stall   i_frequency, i_force_resend, i_band_override
//  result    out        o_out_valid / i_out_stall o_kind, o_value, o_frequency_out, o_last
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A request passes six register stages (request, wrap, quotient, digit, kHz, word set)
// and then the output register. The request then sends one to eleven result words,
// one per cycle while the result side does not stall; the single output register sets
// that pace, and the next request follows without a gap.
// Reset is synchronous: it empties the pipeline, clears the remembered latch values
// and loads the frequency limits with 50000 and 3000000.
// While a request still has words to send, the whole pipeline holds and o_in_stall is
// high; a stall on the result side lengthens that hold.
module dual_pll_tuning_word_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [23:0] i_frequency,
    input  logic        i_force_resend,
    input  logic [7:0]  i_band_override,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_value,
    output logic [23:0] o_frequency_out,
    output logic        o_last
);

    dpts_pkg::t_front front;
    dpts_pkg::t_digit digit;
    dpts_pkg::t_set   set_word;
    logic [10:0]      mask;
    logic             adv;
    logic             load;

    assign o_in_stall = !adv;
    assign load       = adv && digit.req.valid;

    dpts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_adv          (adv),
        .i_in_valid     (i_in_valid),
        .i_frequency    (i_frequency),
        .i_force_resend (i_force_resend),
        .i_band_override(i_band_override),
        .o_front        (front)
    );

    dpts_digits u_digits (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_front(front),
        .o_digit(digit)
    );

    dpts_decide u_decide (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_digit(digit),
        .o_set  (set_word),
        .o_mask (mask)
    );

    dpts_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_set          (set_word),
        .i_mask         (mask),
        .o_take         (adv),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_value        (o_value),
        .o_frequency_out(o_frequency_out),
        .o_last         (o_last)
    );

endmodule

// File: tb/dpts_checker.sv
// Checker for the dual PLL tuning word sequencer: predicts every result word and compares it.
module dpts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [23:0] i_frequency,
    input  logic        i_force_resend,
    input  logic [7:0]  i_band_override,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_value,
    input  logic [23:0] i_frequency_out,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_words_checked
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [23:0] freq;
        logic        last;
    } t_word;

    localparam int unsigned MAX_PRINTED = 40;

    // Tuning limits and the latch values the synthesizers currently hold.
    logic [23:0] lim_lo;
    logic [23:0] lim_hi;
    logic [7:0]  band_now;
    logic [7:0]  band_sent;
    logic [10:0] khz_sent;
    logic [9:0]  count_sent;
    logic [3:0]  tens_sent;

    t_word expected_words[$];
    t_word head_word;
    int    err_cnt = 0;
    int    checked_cnt = 0;

    task automatic report(input string what);
        err_cnt++;
        if (err_cnt <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic void queue_word(input logic [2:0] kind, input int unsigned value,
                                       input logic [23:0] freq, input logic last);
        t_word w;
        w.kind  = kind;
        w.value = value[7:0];
        w.freq  = freq;
        w.last  = last;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_words(input logic [23:0] req_freq, input logic resend,
                                          input logic [7:0] ovr);
        logic [23:0] f;
        int unsigned count;
        int unsigned khz;
        int unsigned x;
        int unsigned tens;
        f = req_freq;
        // The two wrap steps run in sequence, so inverted limits can chain.
        if (f > lim_hi) f = lim_lo;
        if (f < lim_lo) f = lim_hi;
        if (resend) begin
            khz_sent   = '0;
            count_sent = '0;
            band_sent  = '0;
            tens_sent  = '0;
        end
        if (ovr == dpts_pkg::BAND_AUTO) begin
            // At or above the top rung the previous band stays in effect.
            if (f < 24'd9999999) band_now = 8'd9;
            if (f < 24'd2500000) band_now = 8'd8;
            if (f < 24'd2150000) band_now = 8'd7;
            if (f < 24'd1850000) band_now = 8'd6;
            if (f < 24'd1450000) band_now = 8'd5;
            if (f < 24'd1050000) band_now = 8'd4;
            if (f < 24'd750000)  band_now = 8'd3;
            if (f < 24'd400000)  band_now = 8'd2;
            if (f < 24'd250000)  band_now = 8'd1;
        end else begin
            band_now = ovr;
        end
        if (band_now != band_sent) begin
            tens_sent = '0;
            queue_word(dpts_pkg::KIND_BAND, band_now, f, 1'b0);
            band_sent = band_now;
        end

        count = f / 10000;
        khz   = (f / 100) % 1000;
        tens  = f % 10;
        if (khz >= 500) khz -= 500;
        khz += 560;

        if (khz != khz_sent) begin
            queue_word(dpts_pkg::KIND_SYN1, 32'h30, f, 1'b0);
            queue_word(dpts_pkg::KIND_SYN1, 32'h20 + (khz >> 8), f, 1'b0);
            queue_word(dpts_pkg::KIND_SYN1, 32'h10 + ((khz >> 4) & 15), f, 1'b0);
            queue_word(dpts_pkg::KIND_SYN1, khz & 15, f, 1'b0);
            khz_sent = khz[10:0];
        end

        // Only ten bits of the band count are remembered; the words use all of it.
        if (count[9:0] != count_sent) begin
            if (band_now < 8'd6) x = (count / 5 + 12) & 32'hFFFF;
            else                 x = (count / 5 - 18) & 32'hFFFF;
            queue_word(dpts_pkg::KIND_SYN2, 32'h30, f, 1'b0);
            queue_word(dpts_pkg::KIND_SYN2, 32'h20, f, 1'b0);
            queue_word(dpts_pkg::KIND_SYN2, 32'h10 + (x >> 4), f, 1'b0);
            queue_word(dpts_pkg::KIND_SYN2, x & 15, f, 1'b0);
            count_sent = count[9:0];
        end

        if (tens != tens_sent) begin
            queue_word(dpts_pkg::KIND_TENS, tens + 1, f, 1'b0);
            tens_sent = tens[3:0];
        end

        queue_word(dpts_pkg::KIND_HUND, (f / 10) % 10 + 1, f, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_lo     = 24'd50000;
            lim_hi     = 24'd3000000;
            band_now   = '0;
            band_sent  = '0;
            khz_sent   = '0;
            count_sent = '0;
            tens_sent  = '0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == dpts_pkg::REG_MIN_FREQ)      lim_lo = i_cfg_data;
                else if (i_cfg_idx == dpts_pkg::REG_MAX_FREQ) lim_hi = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_words(i_frequency, i_force_resend, i_band_override);
            end
            if ($isunknown(i_out_valid)) begin
                report("result valid is unknown");
            end else if (i_out_valid && !i_out_stall) begin
                checked_cnt++;
                if (expected_words.size() == 0) begin
                    report($sformatf("unexpected word kind %0d value 0x%02h", i_kind, i_value));
                end else begin
                    head_word = expected_words.pop_front();
                    if (i_kind !== head_word.kind)
                        report($sformatf("kind %0d, expected %0d", i_kind, head_word.kind));
                    if (i_value !== head_word.value)
                        report($sformatf("kind %0d value 0x%02h, expected 0x%02h",
                                         head_word.kind, i_value, head_word.value));
                    if (i_frequency_out !== head_word.freq)
                        report($sformatf("frequency %0d, expected %0d",
                                         i_frequency_out, head_word.freq));
                    if (i_last !== head_word.last)
                        report($sformatf("last %b, expected %b", i_last, head_word.last));
                end
            end
        end
        o_errors        <= err_cnt;
        o_pending       <= expected_words.size();
        o_words_checked <= checked_cnt;
    end

endmodule

// File: tb/dual_pll_tuning_word_sequencer_tb.sv
// Testbench top for the dual PLL tuning word sequencer: stimulus, limit settings and verdict.
module dual_pll_tuning_word_sequencer_tb;

    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned SETTLE_WAIT = 12;
    // Indexes past the register list; writes to them must be ignored.
    localparam logic [1:0]  REG_SPARE_A = 2'd2;
    localparam logic [1:0]  REG_SPARE_B = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] frequency;
    logic        force_resend;
    logic [7:0]  band_override;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [23:0] frequency_out;
    logic        last;

    int errors;
    int words_pending;
    int words_checked;

    logic [23:0] stim_lo = dpts_pkg::MIN_FREQ_RST;
    logic [23:0] stim_hi = dpts_pkg::MAX_FREQ_RST;
    logic [23:0] prev_freq = '0;
    logic        quiet = 1'b0;
    int          req_sent = 0;
    int          settings = 1;
    int unsigned idle_cycles = 0;

    logic [23:0] ladder [9] = '{dpts_pkg::THR_B1, dpts_pkg::THR_B2, dpts_pkg::THR_B3,
                                dpts_pkg::THR_B4, dpts_pkg::THR_B5, dpts_pkg::THR_B6,
                                dpts_pkg::THR_B7, dpts_pkg::THR_B8, dpts_pkg::THR_B9};

    dual_pll_tuning_word_sequencer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_frequency     (frequency),
        .i_force_resend  (force_resend),
        .i_band_override (band_override),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (kind),
        .o_value         (value),
        .o_frequency_out (frequency_out),
        .o_last          (last)
    );

    dpts_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_frequency     (frequency),
        .i_force_resend  (force_resend),
        .i_band_override (band_override),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_kind          (kind),
        .i_value         (value),
        .i_frequency_out (frequency_out),
        .i_last          (last),
        .o_errors        (errors),
        .o_pending       (words_pending),
        .o_words_checked (words_checked)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one; none at all in quiet stretches.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [23:0] pick_frequency();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 45) return 24'($urandom_range(stim_hi, stim_lo));
        // Small retunes leave most latch words unchanged.
        if (r < 65) return 24'(prev_freq + $urandom_range(40, 0) - 20);
        if (r < 80) return 24'(ladder[$urandom_range(8, 0)] + $urandom_range(2, 0) - 1);
        if (r < 90) begin
            case ($urandom_range(3, 0))
                0:       return stim_lo - 24'd1;
                1:       return stim_lo;
                2:       return stim_hi;
                default: return stim_hi + 24'd1;
            endcase
        end
        return 24'($urandom);
    endfunction

    function automatic logic [7:0] pick_override();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70) return dpts_pkg::BAND_AUTO;
        if (r < 90) return 8'($urandom_range(15, 0));
        return 8'($urandom_range(254, 0));
    endfunction

    task automatic send_request(input logic [23:0] f, input logic resend,
                                input logic [7:0] ovr);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        frequency     <= f;
        force_resend  <= resend;
        band_override <= ovr;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        prev_freq = f;
        req_sent++;
    endtask

    // Let every expected word arrive, then give the pipeline time to empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic program_limits(input logic [23:0] lo, input logic [23:0] hi);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= dpts_pkg::REG_MIN_FREQ;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx  <= dpts_pkg::REG_MAX_FREQ;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_idx  <= ($urandom_range(1, 0) != 0) ? REG_SPARE_A : REG_SPARE_B;
        cfg_data <= 24'($urandom);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        stim_lo = lo;
        stim_hi = hi;
        settings++;
    endtask

    task automatic run_random(input int unsigned n);
        repeat (n) begin
            if ($urandom_range(99, 0) < 5) quiet = ~quiet;
            send_request(pick_frequency(), $urandom_range(99, 0) < 12, pick_override());
        end
    endtask

    // Result side: runs of ready cycles broken by stalls of random length.
    initial begin
        int unsigned len;
        forever begin
            len = $urandom_range(12, 1);
            out_stall <= 1'b0;
            repeat (len) @(posedge i_clk);
            len = gap_len();
            if (len > 0) begin
                out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned lo;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= dpts_pkg::REG_MIN_FREQ;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        frequency     <= '0;
        force_resend  <= 1'b0;
        band_override <= dpts_pkg::BAND_AUTO;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: wrap in both directions, repeats, forced resend, band ladder.
        send_request(24'd0, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'hFFFFFF, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd50000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd50000, 1'b1, dpts_pkg::BAND_AUTO);
        send_request(24'd3000000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd249999, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd250000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd399999, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd400000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd750000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd1049999, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd1450000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd1850000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd2149999, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd2150000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd2500000, 1'b0, dpts_pkg::BAND_AUTO);
        // Upper half of the kHz range folds; a forced band change resends the tens digit.
        send_request(24'd1275993, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd1275993, 1'b0, 8'd0);
        send_request(24'd1275993, 1'b0, 8'd254);
        // High band with a small count drives the synth-2 value below zero.
        send_request(24'd50007, 1'b0, 8'd7);
        run_random(20);

        // Widest limits: the top rung keeps the band and the count exceeds ten bits.
        program_limits(24'd0, 24'hFFFFFF);
        send_request(24'd9999999, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'hFFFFFF, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd0, 1'b1, dpts_pkg::BAND_AUTO);
        run_random(35);

        // Minimum above maximum.
        program_limits(24'd3000000, 24'd50000);
        send_request(24'd100000, 1'b0, dpts_pkg::BAND_AUTO);
        send_request(24'd10000, 1'b0, dpts_pkg::BAND_AUTO);
        run_random(25);

        program_limits(24'd0, 24'd0);
        run_random(15);

        program_limits(24'd9999999, 24'd9999999);
        send_request(24'd9999999, 1'b1, dpts_pkg::BAND_AUTO);
        run_random(15);

        repeat (2) begin
            lo = $urandom_range(2000000, 0);
            program_limits(24'(lo), 24'($urandom_range(9999999, lo)));
            run_random(20);
        end

        program_limits(dpts_pkg::MIN_FREQ_RST, dpts_pkg::MAX_FREQ_RST);
        run_random(30);

        settle();
        $display("summary: %0d tuning requests under %0d limit settings, %0d result words checked",
                 req_sent, settings, words_checked);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
